FILE: sv/prps_pkg.sv
`default_nettype none
package prps_pkg;

  localparam int COORD_BITS     = 24;
  localparam int CFG_COORD_BITS = 24;
  localparam int FAR_BITS       = 24;
  localparam int OFF_BITS       = COORD_BITS + 3;
  localparam int RSQ_BITS       = 48;
  localparam int SQ_BITS        = 2 * FAR_BITS;
  localparam int SUM_BITS       = SQ_BITS + 2;
  localparam int CFG_DATA_BITS  = 48;
  localparam int CFG_ADDR_BITS  = 3;

  localparam logic [CFG_ADDR_BITS-1:0] REG_CENTER_X    = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_CENTER_Y    = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_CENTER_Z    = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_BOX_LENGTH  = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SHAPE_MODE  = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_HALF_EXTENT = 3'd5;
  localparam logic [CFG_ADDR_BITS-1:0] REG_RADIUS_SQ   = 3'd6;

  localparam logic SHAPE_CUBE   = 1'b0;
  localparam logic SHAPE_SPHERE = 1'b1;

  localparam logic [CFG_COORD_BITS-1:0] BOX_LENGTH_RESET = '1;

  typedef struct packed {
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [COORD_BITS-1:0] center_z;
    logic [COORD_BITS-1:0] box_length;
    logic                  shape_mode;
    logic [COORD_BITS-1:0] half_extent;
    logic [RSQ_BITS-1:0]   radius_squared;
  } cfg_t;

  typedef struct packed {
    logic                ok;
    logic                far;
    logic [FAR_BITS-1:0] mag;
  } axis_t;

endpackage
`default_nettype wire

FILE: sv/periodic_region_particle_select.sv
`default_nettype none
// Periodic region particle select. One particle position per beat; each axis
// offset from the configured center is wrapped once into [-box/2, box/2) and
// tested against the half extent, and sphere mode also checks the sum of
// squared offsets against radius_squared. A new beat is accepted every cycle
// unless all stages are full and the output stalls. Beats move from the input
// register through wrap/range, squaring, sum/compare to the result register.
// Up to four beats are held when the output stalls. Configuration is written
// through cfg_we/cfg_addr/cfg_wdata and must only change while idle.
module periodic_region_particle_select (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [prps_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
  input  wire logic [prps_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [prps_pkg::COORD_BITS-1:0]     pos_x,
  input  wire logic [prps_pkg::COORD_BITS-1:0]     pos_y,
  input  wire logic [prps_pkg::COORD_BITS-1:0]     pos_z,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     selected
);
  import prps_pkg::*;

  cfg_t cfg;

  logic                  s1_v;
  logic [COORD_BITS-1:0] s1_x;
  logic [COORD_BITS-1:0] s1_y;
  logic [COORD_BITS-1:0] s1_z;

  logic                  s2_v;
  axis_t                 s2_ax;
  axis_t                 s2_ay;
  axis_t                 s2_az;

  logic                  s3_v;
  logic                  s3_all_ok;
  logic                  s3_any_far;
  logic [SQ_BITS-1:0]    s3_sq_x;
  logic [SQ_BITS-1:0]    s3_sq_y;
  logic [SQ_BITS-1:0]    s3_sq_z;

  axis_t                 ax;
  axis_t                 ay;
  axis_t                 az;

  logic                  load_out;
  logic                  load_s3;
  logic                  load_s2;
  logic                  load_s1;

  logic [SUM_BITS-1:0]   sum;
  logic                  fit;
  logic                  sel_next;

  prps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  prps_axis u_axis_x (
    .pos(s1_x), .center(cfg.center_x), .box(cfg.box_length),
    .extent(cfg.half_extent), .res(ax)
  );
  prps_axis u_axis_y (
    .pos(s1_y), .center(cfg.center_y), .box(cfg.box_length),
    .extent(cfg.half_extent), .res(ay)
  );
  prps_axis u_axis_z (
    .pos(s1_z), .center(cfg.center_z), .box(cfg.box_length),
    .extent(cfg.half_extent), .res(az)
  );

  assign load_out = !out_valid || out_ready;
  assign load_s3  = !s3_v || load_out;
  assign load_s2  = !s2_v || load_s3;
  assign load_s1  = !s1_v || load_s2;
  assign in_ready = load_s1;

  assign sum = SUM_BITS'(s3_sq_x) + SUM_BITS'(s3_sq_y) + SUM_BITS'(s3_sq_z);
  assign fit = !s3_any_far && (sum <= SUM_BITS'(cfg.radius_squared));
  assign sel_next = s3_all_ok && ((cfg.shape_mode != SHAPE_SPHERE) || fit);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_s1) begin
        s1_v <= in_valid;
      end
      if (load_s2) begin
        s2_v <= s1_v;
      end
      if (load_s3) begin
        s3_v <= s2_v;
      end
      if (load_out) begin
        out_valid <= s3_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_s1) begin
      s1_x <= pos_x;
      s1_y <= pos_y;
      s1_z <= pos_z;
    end
    if (load_s2) begin
      s2_ax <= ax;
      s2_ay <= ay;
      s2_az <= az;
    end
    if (load_s3) begin
      s3_all_ok  <= s2_ax.ok && s2_ay.ok && s2_az.ok;
      s3_any_far <= s2_ax.far || s2_ay.far || s2_az.far;
      s3_sq_x    <= (s2_ax.ok && !s2_ax.far) ? s2_ax.mag * s2_ax.mag : '0;
      s3_sq_y    <= (s2_ay.ok && !s2_ay.far) ? s2_ay.mag * s2_ay.mag : '0;
      s3_sq_z    <= (s2_az.ok && !s2_az.far) ? s2_az.mag * s2_az.mag : '0;
    end
    if (load_out) begin
      selected <= sel_next;
    end
  end

endmodule
`default_nettype wire

FILE: sv/prps_cfg.sv
`default_nettype none
module prps_cfg (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [prps_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  wire logic [prps_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  output prps_pkg::cfg_t                            cfg
);
  import prps_pkg::*;

  logic [COORD_BITS-1:0] coord_val;

  assign coord_val = COORD_BITS'(cfg_wdata[CFG_COORD_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x       <= '0;
      cfg.center_y       <= '0;
      cfg.center_z       <= '0;
      cfg.box_length     <= COORD_BITS'(BOX_LENGTH_RESET);
      cfg.shape_mode     <= SHAPE_CUBE;
      cfg.half_extent    <= '0;
      cfg.radius_squared <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CENTER_X:    cfg.center_x       <= coord_val;
        REG_CENTER_Y:    cfg.center_y       <= coord_val;
        REG_CENTER_Z:    cfg.center_z       <= coord_val;
        REG_BOX_LENGTH:  cfg.box_length     <= coord_val;
        REG_SHAPE_MODE:  cfg.shape_mode     <= cfg_wdata[0];
        REG_HALF_EXTENT: cfg.half_extent    <= coord_val;
        REG_RADIUS_SQ:   cfg.radius_squared <= cfg_wdata[RSQ_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sv/prps_axis.sv
`default_nettype none
module prps_axis (
  input  wire logic [prps_pkg::COORD_BITS-1:0] pos,
  input  wire logic [prps_pkg::COORD_BITS-1:0] center,
  input  wire logic [prps_pkg::COORD_BITS-1:0] box,
  input  wire logic [prps_pkg::COORD_BITS-1:0] extent,
  output prps_pkg::axis_t                      res
);
  import prps_pkg::*;

  logic signed [OFF_BITS-1:0] d;
  logic signed [OFF_BITS-1:0] d2;
  logic signed [OFF_BITS-1:0] b;
  logic signed [OFF_BITS-1:0] ext;
  logic signed [OFF_BITS-1:0] w;
  logic signed [OFF_BITS-1:0] w_abs;
  logic                       in_range;
  logic [COORD_BITS-1:0]      mag_full;

  assign d   = $signed({3'b000, pos}) - $signed({3'b000, center});
  assign d2  = d <<< 1;
  assign b   = $signed({3'b000, box});
  assign ext = $signed({3'b000, extent});

  // single wrap into [-box/2, box/2)
  always_comb begin
    if (d2 < -b) begin
      w = d + b;
    end else if (d2 >= b) begin
      w = d - b;
    end else begin
      w = d;
    end
  end

  assign in_range = (w >= -ext) && (w <= ext);
  assign w_abs    = w[OFF_BITS-1] ? -w : w;
  assign mag_full = w_abs[COORD_BITS-1:0];

  assign res.ok  = in_range;
  assign res.far = in_range && ((mag_full >> FAR_BITS) != '0);
  assign res.mag = FAR_BITS'(mag_full);

endmodule
`default_nettype wire

FILE: sv/prps_checker.sv
`default_nettype none
module prps_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic selected
);

  logic [2:0] cnt;
  logic [2:0] cnt_next;

  always_comb begin
    cnt_next = cnt;
    if (in_valid && in_ready) begin
      cnt_next = cnt_next + 3'd1;
    end
    if (out_valid && out_ready) begin
      cnt_next = cnt_next - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(selected))
    else $error("output beat changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cnt != 3'd0)
    else $error("output beat without a matching input beat");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    cnt <= 3'd4)
    else $error("more beats in flight than pipeline stages");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready && cnt == 3'd4)
    else $error("input stalled while pipeline can move");

endmodule

bind periodic_region_particle_select prps_checker u_prps_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .selected  (selected)
);
`default_nettype wire
